// ===== hw/rtl/mtl_pkg.sv =====
// Package for the markup tag lexer: token and scan-mode types, byte codes,
// and helpers for byte classes and span lengths. No dependencies.
`timescale 1ns / 1ps

package mtl_pkg;

	localparam int POS_BITS = 16;
	localparam int DIFF_W   = (POS_BITS + 1 > 17) ? POS_BITS + 1 : 17;
	localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
	localparam logic [15:0] LEN_MAX = 16'hFFFF;

	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_IDENT,
		MODE_DQ,
		MODE_SQ,
		MODE_SLASH
	} mode_t;

	typedef enum logic [2:0] {
		K_SPACE   = 3'd0,
		K_IDENT   = 3'd1,
		K_LESS    = 3'd2,
		K_GREATER = 3'd3,
		K_SLASHGT = 3'd4,
		K_EQUALS  = 3'd5,
		K_EOF     = 3'd6,
		K_STRING  = 3'd7
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] start;
		logic [15:0] length;
		logic        last;
	} tok_t;

	typedef struct packed {
		logic [1:0] cnt;
		tok_t       tok0;
		tok_t       tok1;
	} step_t;

	typedef struct packed {
		logic  emit;
		kind_t kind;
		logic  opens;
		mode_t mode;
	} fresh_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SP) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	// Classify a byte seen with no token open.
	function automatic fresh_t lex_fresh(input logic [7:0] c);
		fresh_t f;
		f = '{emit: 1'b0, kind: K_SPACE, opens: 1'b0, mode: MODE_IDLE};
		if (is_space(c)) begin
			f.emit = 1'b1;
			f.kind = K_SPACE;
		end else if (is_letter(c)) begin
			f.opens = 1'b1;
			f.mode  = MODE_IDENT;
		end else if (c == CH_LT) begin
			f.emit = 1'b1;
			f.kind = K_LESS;
		end else if (c == CH_GT) begin
			f.emit = 1'b1;
			f.kind = K_GREATER;
		end else if (c == CH_EQ) begin
			f.emit = 1'b1;
			f.kind = K_EQUALS;
		end else if (c == CH_NUL) begin
			f.emit = 1'b1;
			f.kind = K_EOF;
		end else if (c == CH_SLASH) begin
			f.opens = 1'b1;
			f.mode  = MODE_SLASH;
		end else if (c == CH_DQ) begin
			f.opens = 1'b1;
			f.mode  = MODE_DQ;
		end else if (c == CH_SQ) begin
			f.opens = 1'b1;
			f.mode  = MODE_SQ;
		end
		return f;
	endfunction

	// Span from s to p, plus one when the current byte is included; clamp to [1, 65535].
	function automatic logic [15:0] span_len(input logic [POS_BITS-1:0] p,
	                                         input logic [POS_BITS-1:0] s,
	                                         input logic plus1);
		logic [DIFF_W-1:0] d;
		d = DIFF_W'(p) - DIFF_W'(s) + DIFF_W'(plus1);
		if (d == '0) begin
			return 16'd1;
		end else if (d > DIFF_W'(LEN_MAX)) begin
			return LEN_MAX;
		end
		return d[15:0];
	endfunction

	function automatic tok_t mk_tok(input kind_t k, input logic [POS_BITS-1:0] s,
	                                input logic [15:0] len);
		tok_t t;
		t.kind   = k;
		t.start  = 16'(s);
		t.length = len;
		t.last   = 1'b0;
		return t;
	endfunction

endpackage

// ===== hw/rtl/mtl_lexer.sv =====
// One lexing step: from the scan state and one byte, the next scan state and
// up to two tokens. Pure combinational logic; depends on mtl_pkg.
`timescale 1ns / 1ps

module mtl_lexer (
	input  mtl_pkg::mode_t                mode,
	input  logic [mtl_pkg::POS_BITS-1:0] pstart,
	input  logic [mtl_pkg::POS_BITS-1:0] pos,
	input  logic [7:0]                   ch,
	input  logic                         stream_end,
	output mtl_pkg::mode_t                mode_nxt,
	output logic [mtl_pkg::POS_BITS-1:0] pstart_nxt,
	output logic [mtl_pkg::POS_BITS-1:0] pos_nxt,
	output mtl_pkg::step_t                step
);

	mtl_pkg::fresh_t fr;
	mtl_pkg::mode_t  mode_mid;
	logic [mtl_pkg::POS_BITS-1:0] pstart_mid;
	logic [7:0] quote;
	logic       ident_ends;
	logic       fresh_used;

	assign fr         = mtl_pkg::lex_fresh(ch);
	assign quote      = (mode == mtl_pkg::MODE_DQ) ? mtl_pkg::CH_DQ : mtl_pkg::CH_SQ;
	assign ident_ends = !(mtl_pkg::is_letter(ch) || ch == mtl_pkg::CH_DASH);

	// Next state
	always_comb begin
		mode_mid   = mode;
		pstart_mid = pstart;
		fresh_used = 1'b0;
		case (mode)
			mtl_pkg::MODE_IDENT: begin
				if (ident_ends) begin
					mode_mid   = mtl_pkg::MODE_IDLE;
					fresh_used = 1'b1;
				end
			end
			mtl_pkg::MODE_DQ, mtl_pkg::MODE_SQ: begin
				if (ch == quote) begin
					mode_mid = mtl_pkg::MODE_IDLE;
				end
			end
			mtl_pkg::MODE_SLASH: begin
				mode_mid   = mtl_pkg::MODE_IDLE;
				fresh_used = (ch != mtl_pkg::CH_GT);
			end
			default: begin
				mode_mid   = mtl_pkg::MODE_IDLE;
				fresh_used = 1'b1;
			end
		endcase
		if (fresh_used && fr.opens) begin
			mode_mid   = fr.mode;
			pstart_mid = pos;
		end
		if (stream_end) begin
			mode_nxt   = mtl_pkg::MODE_IDLE;
			pstart_nxt = '0;
			pos_nxt    = '0;
		end else begin
			mode_nxt   = mode_mid;
			pstart_nxt = pstart_mid;
			pos_nxt    = (pos < mtl_pkg::POS_MAX) ? pos + 1'b1 : pos;
		end
	end

	// Tokens
	always_comb begin
		mtl_pkg::tok_t res [2];
		logic [1:0] cnt;
		res[0] = '0;
		res[1] = '0;
		cnt    = 2'd0;
		case (mode)
			mtl_pkg::MODE_IDENT: begin
				if (ident_ends) begin
					res[cnt[0]] = mtl_pkg::mk_tok(mtl_pkg::K_IDENT, pstart,
						mtl_pkg::span_len(pos, pstart, 1'b0));
					cnt = cnt + 2'd1;
				end
			end
			mtl_pkg::MODE_DQ, mtl_pkg::MODE_SQ: begin
				if (ch == quote) begin
					res[cnt[0]] = mtl_pkg::mk_tok(mtl_pkg::K_STRING, pstart,
						mtl_pkg::span_len(pos, pstart, 1'b1));
					cnt = cnt + 2'd1;
				end
			end
			mtl_pkg::MODE_SLASH: begin
				if (ch == mtl_pkg::CH_GT) begin
					res[cnt[0]] = mtl_pkg::mk_tok(mtl_pkg::K_SLASHGT, pstart,
						mtl_pkg::span_len(pos, pstart, 1'b1));
					cnt = cnt + 2'd1;
				end
			end
			default: begin
			end
		endcase
		if (fresh_used && fr.emit) begin
			res[cnt[0]] = mtl_pkg::mk_tok(fr.kind, pos, 16'd1);
			cnt = cnt + 2'd1;
		end
		// Flush an open identifier or string at end of stream.
		if (stream_end && mode_mid == mtl_pkg::MODE_IDENT) begin
			res[cnt[0]] = mtl_pkg::mk_tok(mtl_pkg::K_IDENT, pstart_mid,
				mtl_pkg::span_len(pos, pstart_mid, 1'b1));
			cnt = cnt + 2'd1;
		end else if (stream_end &&
		             (mode_mid == mtl_pkg::MODE_DQ || mode_mid == mtl_pkg::MODE_SQ)) begin
			res[cnt[0]] = mtl_pkg::mk_tok(mtl_pkg::K_STRING, pstart_mid,
				mtl_pkg::span_len(pos, pstart_mid, 1'b1));
			cnt = cnt + 2'd1;
		end
		if (cnt == 2'd1) begin
			res[0].last = 1'b1;
		end else if (cnt == 2'd2) begin
			res[1].last = 1'b1;
		end
		step.cnt  = cnt;
		step.tok0 = res[0];
		step.tok1 = res[1];
	end

endmodule

// ===== hw/rtl/markup_tag_lexer_core.sv =====
// Top level of the markup tag lexer: input register, scan state, token queue.
// Depends on mtl_pkg and mtl_lexer.
//
//   channel | words                              | flow control
//   --------+------------------------------------+----------------------------
//   in      | ch, stream_end                     | in_valid / in_stall
//   out     | token_kind, token_start,           | out_valid / out_stall
//           | token_length, run_last             |
//
// One byte is accepted per cycle while in_stall is low. A byte is
// registered, lexed in the next cycle and its zero to two tokens are written
// to an eight-word queue; the first token is visible in the cycle after.
// Two-token bytes need two output transfers: the port sets the sustained rate.
// arst_n clears scan state, position and queue pointers.
// in_stall rises when the queue could not absorb two more tokens from the
// byte in flight plus the next one; out_stall just holds the queue head.
`timescale 1ns / 1ps

module markup_tag_lexer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  ch,
	input  logic        stream_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  token_kind,
	output logic [15:0] token_start,
	output logic [15:0] token_length,
	output logic        run_last
);

	// Input register
	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       end_s1;

	// Scan state
	mtl_pkg::mode_t mode_q;
	logic [mtl_pkg::POS_BITS-1:0] pstart_q;
	logic [mtl_pkg::POS_BITS-1:0] pos_q;

	mtl_pkg::mode_t mode_nxt;
	logic [mtl_pkg::POS_BITS-1:0] pstart_nxt;
	logic [mtl_pkg::POS_BITS-1:0] pos_nxt;
	mtl_pkg::step_t step;

	// Token queue
	mtl_pkg::tok_t fifo_q [8];
	logic [2:0] wr_ptr_q;
	logic [2:0] rd_ptr_q;
	logic [3:0] count_q;
	logic [1:0] push;
	logic       pop;
	logic       in_take;

	// Hold off when the queue could overflow from the byte in flight and a new one.
	assign in_stall = (count_q + (valid_s1 ? 4'd2 : 4'd0)) > 4'd6;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_take;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			ch_s1  <= ch;
			end_s1 <= stream_end;
		end
	end

	mtl_lexer u_lexer (
		.mode       (mode_q),
		.pstart     (pstart_q),
		.pos        (pos_q),
		.ch         (ch_s1),
		.stream_end (end_s1),
		.mode_nxt   (mode_nxt),
		.pstart_nxt (pstart_nxt),
		.pos_nxt    (pos_nxt),
		.step       (step)
	);

	// Advance the scan state once per lexed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= mtl_pkg::MODE_IDLE;
			pstart_q <= '0;
			pos_q    <= '0;
		end else if (valid_s1) begin
			mode_q   <= mode_nxt;
			pstart_q <= pstart_nxt;
			pos_q    <= pos_nxt;
		end
	end

	assign push = valid_s1 ? step.cnt : 2'd0;
	assign pop  = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		if (push != 2'd0) begin
			fifo_q[wr_ptr_q] <= step.tok0;
		end
		if (push == 2'd2) begin
			fifo_q[wr_ptr_q + 3'd1] <= step.tok1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + 3'(push);
			rd_ptr_q <= rd_ptr_q + 3'(pop);
			count_q  <= count_q + 4'(push) - 4'(pop);
		end
	end

	// Drive the queue head onto the output port.
	assign out_valid    = (count_q != 4'd0);
	assign token_kind   = fifo_q[rd_ptr_q].kind;
	assign token_start  = fifo_q[rd_ptr_q].start;
	assign token_length = fifo_q[rd_ptr_q].length;
	assign run_last     = fifo_q[rd_ptr_q].last;

endmodule
